>>> rtl/mme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants of the matrix multiply engine
// fixed point widths, op codes, register indexes, sequencer states
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int MAX_DIM    = 8;
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int DIM_W      = 4;
  localparam int IDX_W      = 6;
  localparam int POS_W      = 3;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ACC_W      = PROD_W + $clog2(MAX_DIM);
  localparam int SH_W       = ACC_W - FRAC_BITS;
  localparam int AREA_W     = 2 * DIM_W;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int OP_W       = 2;
  localparam int CFG_ADDR_W = 2;

  localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } seq_state_t;

  // control from sequencer to the mac unit
  typedef struct packed {
    logic issue;  // operand addresses presented to the stores this cycle
    logic clear;  // zero the accumulator
  } mac_ctl_t;

  // status from the mac unit
  typedef struct packed {
    logic rd_pend;  // operand read still on its way into the multiplier
    logic sat;      // finished sum was clipped
  } mac_sts_t;

  // register value used as a dimension: 0 acts as 1, above MAX_DIM as MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
    logic [DIM_W-1:0] d;
    if (r == '0) begin
      d = DIM_W'(1);
    end else if (r > DIM_W'(MAX_DIM)) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = r;
    end
    return d;
  endfunction

endpackage

>>> rtl/mme_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_ram: generic single write, single read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module mme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/mme_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_mac: shared multiply-accumulate unit
// registered 32x32 product, exact wide accumulator, floor shift and saturate
// ----------------------------------------------------------------------------
module mme_mac
  import mme_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mac_ctl_t          ctl,
  input  logic [DATA_W-1:0] a_data,
  input  logic [DATA_W-1:0] b_data,
  output mac_sts_t          sts,
  output logic [DATA_W-1:0] result
);

  logic              rd_vld_r, rd_vld_nxt;
  logic              mul_vld_r, mul_vld_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [SH_W-1:0]   shifted;
  logic              in_range;

  always_comb begin
    rd_vld_nxt  = ctl.issue;
    mul_vld_nxt = rd_vld_r;
    prod_nxt    = PROD_W'($signed(a_data) * $signed(b_data));
    acc_nxt     = acc_r;
    if (mul_vld_r) begin
      acc_nxt = acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
    if (ctl.clear) begin
      acc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= rd_vld_nxt;
      mul_vld_r <= mul_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  // floor shift is a plain select of the upper bits
  assign shifted  = acc_r[ACC_W-1:FRAC_BITS];
  assign in_range = (&shifted[SH_W-1:DATA_W-1]) | ~(|shifted[SH_W-1:DATA_W-1]);

  always_comb begin
    if (in_range) begin
      result = shifted[DATA_W-1:0];
    end else if (shifted[SH_W-1]) begin
      result = SAT_NEG;
    end else begin
      result = SAT_POS;
    end
  end

  assign sts.rd_pend = rd_vld_r;
  assign sts.sat     = ~in_range;

endmodule

>>> rtl/matrix_multiply_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_engine: C = A x B in signed Q16.16
// element stores for A and B, a sequencer and one shared mac unit
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents (lsb first)                              tlast
//  in_       in   tuser: op[1:0]; tdata: elem_index[5:0], elem_value[37:6] -
//  out_      out  tdata: result_value[31:0], result_row[34:32],          last
//                 result_col[37:35], saturated[38]
//  cfg_      in   cfg_addr: register index, cfg_wdata: 4-bit value         -
//
//  a load beat (write A or B) writes its store; op 3 is dropped
//  a compute beat works through C element by element: for each it issues K operand
//  reads through the single read port of each store, drains the read and
//  multiply registers, then hands the element to the output register; a
//  stalled output register holds the sequencer in its emit step
//  in_tready is high only while the sequencer is idle
//  rst_n is synchronous; the stores are not cleared, only control state is
// ----------------------------------------------------------------------------
module matrix_multiply_engine
  import mme_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]      cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // elem_index[5:0], elem_value[37:6]
  input  logic [OP_W-1:0]       in_tuser,   // op[1:0]
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // value[31:0], row[34:32], col[37:35], sat[38]
  output logic                  out_tlast   // last element of C
);

  // dimension registers
  logic [DIM_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic [DIM_W-1:0] m_eff, k_eff, n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_W'(1);
      inner_dim_r <= DIM_W'(1);
      cols_b_r    <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROWS_A:    rows_a_r    <= cfg_wdata;
        REG_INNER_DIM: inner_dim_r <= cfg_wdata;
        REG_COLS_B:    cols_b_r    <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  assign m_eff = eff_dim(rows_a_r);
  assign k_eff = eff_dim(inner_dim_r);
  assign n_eff = eff_dim(cols_b_r);

  // input beat fields
  logic [OP_W-1:0]   in_op;
  logic [IDX_W-1:0]  in_idx;
  logic [DATA_W-1:0] in_val;
  logic              in_fire;
  logic [AREA_W-1:0] a_area, b_area;
  logic              a_we, b_we, start;

  assign in_op   = in_tuser;
  assign in_idx  = in_tdata[IDX_W-1:0];
  assign in_val  = in_tdata[IDX_W +: DATA_W];
  assign in_fire = in_tvalid & in_tready;

  // writes beyond the current matrix size are dropped
  assign a_area = AREA_W'(m_eff * k_eff);
  assign b_area = AREA_W'(k_eff * n_eff);
  assign a_we   = in_fire && (in_op == OP_WRITE_A) && (AREA_W'(in_idx) < a_area);
  assign b_we   = in_fire && (in_op == OP_WRITE_B) && (AREA_W'(in_idx) < b_area);
  assign start  = in_fire && (in_op == OP_COMPUTE);

  // sequencer registers
  seq_state_t        state_r, state_nxt;
  logic [POS_W-1:0]  i_r, i_nxt;
  logic [POS_W-1:0]  j_r, j_nxt;
  logic [POS_W-1:0]  t_r, t_nxt;
  logic [IDX_W-1:0]  row_base_r, row_base_nxt;   // i * K
  logic [IDX_W-1:0]  a_addr_r, a_addr_nxt;       // i * K + t
  logic [IDX_W-1:0]  b_addr_r, b_addr_nxt;       // t * N + j

  logic              t_last, j_last, i_last, elem_last;
  logic              emit_fire;
  logic [IDX_W-1:0]  next_row_base;
  mac_ctl_t          mac_ctl;
  mac_sts_t          mac_sts;
  logic [DATA_W-1:0] a_rdata, b_rdata, mac_result;

  // output register
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                  out_tlast_r, out_tlast_nxt;

  assign t_last    = ({1'b0, t_r} == (k_eff - DIM_W'(1)));
  assign j_last    = ({1'b0, j_r} == (n_eff - DIM_W'(1)));
  assign i_last    = ({1'b0, i_r} == (m_eff - DIM_W'(1)));
  assign elem_last = i_last & j_last;
  assign emit_fire = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);
  assign next_row_base = row_base_r + IDX_W'(k_eff);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (t_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // the last product joins the sum on the edge that leaves this state
        if (!mac_sts.rd_pend) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_nxt = elem_last ? ST_IDLE : ST_MAC;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    mac_ctl.issue = (state_r == ST_MAC);
    mac_ctl.clear = start | emit_fire;
  end

  // element and operand counters
  always_comb begin
    i_nxt        = i_r;
    j_nxt        = j_r;
    t_nxt        = t_r;
    row_base_nxt = row_base_r;
    a_addr_nxt   = a_addr_r;
    b_addr_nxt   = b_addr_r;
    if (start) begin
      i_nxt        = '0;
      j_nxt        = '0;
      t_nxt        = '0;
      row_base_nxt = '0;
      a_addr_nxt   = '0;
      b_addr_nxt   = '0;
    end else if (state_r == ST_MAC) begin
      t_nxt      = t_r + POS_W'(1);
      a_addr_nxt = a_addr_r + IDX_W'(1);
      b_addr_nxt = b_addr_r + IDX_W'(n_eff);
    end else if (emit_fire) begin
      t_nxt = '0;
      if (j_last) begin
        j_nxt        = '0;
        i_nxt        = i_r + POS_W'(1);
        row_base_nxt = next_row_base;
        a_addr_nxt   = next_row_base;
        b_addr_nxt   = '0;
      end else begin
        j_nxt      = j_r + POS_W'(1);
        a_addr_nxt = row_base_r;
        b_addr_nxt = IDX_W'(j_r) + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    t_r        <= t_nxt;
    row_base_r <= row_base_nxt;
    a_addr_r   <= a_addr_nxt;
    b_addr_r   <= b_addr_nxt;
  end

  // element stores
  mme_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_a_store (
    .clk  (clk),
    .we   (a_we),
    .waddr(in_idx),
    .wdata(in_val),
    .raddr(a_addr_r),
    .rdata(a_rdata)
  );

  mme_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_b_store (
    .clk  (clk),
    .we   (b_we),
    .waddr(in_idx),
    .wdata(in_val),
    .raddr(b_addr_r),
    .rdata(b_rdata)
  );

  // shared multiply-accumulate
  mme_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a_data(a_rdata),
    .b_data(b_rdata),
    .sts   (mac_sts),
    .result(mac_result)
  );

  // output register parts the sequencer from the result consumer
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    if (emit_fire) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = OUT_DATA_W'({mac_sts.sat, j_r, i_r, mac_result});
      out_tlast_nxt  = elem_last;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

>>> tb/matrix_multiply_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_engine_tb: self-checking bench for the matrix multiply engine
// a directed table at the reset dimensions (saturation, floor rounding, dropped
// writes, unused op), then random phases across many dimension settings; each result
// beat is checked against a typed value or a shadow model of the A and B stores
// ----------------------------------------------------------------------------
module matrix_multiply_engine_tb;
  import mme_pkg::*;

  localparam logic [OP_W-1:0]       OP_UNUSED  = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES  = 16;  // margin for a load or a dropped beat to finish
  localparam int RAND_PER_PHASE = 6;

  // one element of C as it leaves the block
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              sat;
    logic              last;
  } c_elem_t;

  // one row of the directed table; typed rows carry their C element by hand
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] val;
    logic              typed;
    logic [DATA_W-1:0] c_value;
    logic              c_sat;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [DIM_W-1:0]      cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // elem_index[5:0], elem_value[37:6]
  logic [OP_W-1:0]       in_tuser   = '0;  // op[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // value[31:0], row[34:32], col[37:35], sat[38]
  logic                  out_tlast;

  // shadow of the block: element stores and dimension registers
  logic [DATA_W-1:0] a_shadow [STORE_DEPTH];
  logic [DATA_W-1:0] b_shadow [STORE_DEPTH];
  logic [DIM_W-1:0]  m_reg = DIM_W'(1);
  logic [DIM_W-1:0]  k_reg = DIM_W'(1);
  logic [DIM_W-1:0]  n_reg = DIM_W'(1);

  c_elem_t  c_expected [$];
  dir_row_t dir_rows [$];
  int       errors = 0;
  bit       steady = 1'b0;  // phase without any idling on either side
  int       stall_left = 0;

  matrix_multiply_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // register value as a dimension: 0 counts as 1, anything above 8 as 8
  function automatic int dim_used(input logic [DIM_W-1:0] r);
    if (r == '0) return 1;
    if (r > DIM_W'(MAX_DIM)) return MAX_DIM;
    return int'(r);
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int pause_len();
    int pick;
    pick = $urandom_range(0, 19);
    if (steady || pick < 12) return 0;
    if (pick < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // element value: the two extremes, full-range noise, or small Q16.16 numbers
  function automatic logic [DATA_W-1:0] pick_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return SAT_POS;
    if (pick == 1) return SAT_NEG;
    if (pick < 4) return $urandom;
    return DATA_W'($urandom_range(0, 32'h7FFFF)) - DATA_W'(32'h40000);  // about +-4.0
  endfunction

  // exact dot product of row i of A and column j of B, floored to Q16.16
  function automatic c_elem_t c_element(input int i, input int j, input int m,
                                        input int k, input int n);
    logic signed [127:0] acc;
    logic signed [127:0] sh;
    longint pa;
    longint pb;
    c_elem_t e;
    acc = '0;
    for (int t = 0; t < k; t++) begin
      pa = $signed(a_shadow[i * k + t]);
      pb = $signed(b_shadow[t * n + j]);
      acc = acc + (pa * pb);
    end
    sh = acc >>> FRAC_BITS;
    // fits when everything above bit 31 is a copy of the sign
    if (sh[127:31] == '0 || sh[127:31] == '1) begin
      e.value = sh[DATA_W-1:0];
      e.sat   = 1'b0;
    end else begin
      e.value = sh[127] ? SAT_NEG : SAT_POS;
      e.sat   = 1'b1;
    end
    e.row  = POS_W'(i);
    e.col  = POS_W'(j);
    e.last = (i == m - 1) && (j == n - 1);
    return e;
  endfunction

  // update the shadow with an accepted beat and queue the C elements it causes
  task automatic mirror_beat(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] val);
    int m;
    int k;
    int n;
    m = dim_used(m_reg);
    k = dim_used(k_reg);
    n = dim_used(n_reg);
    case (op)
      OP_WRITE_A: begin
        if (int'(idx) < m * k) a_shadow[idx] = val;  // out-of-range writes are dropped
      end
      OP_WRITE_B: begin
        if (int'(idx) < k * n) b_shadow[idx] = val;
      end
      OP_COMPUTE: begin
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < n; j++) begin
            c_expected.push_back(c_element(i, j, m, k, n));
          end
        end
      end
      default: ;  // unused op is dropped
    endcase
  endtask

  // one input beat; valid stays up across back-to-back beats
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] val);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [DIM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    case (addr)
      REG_ROWS_A:    m_reg = val;
      REG_INNER_DIM: k_reg = val;
      REG_COLS_B:    n_reg = val;
      default: ;  // no register behind this index
    endcase
  endtask

  // raw register values; the unused index gets a random write each time
  task automatic set_dims(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] k,
                          input logic [DIM_W-1:0] n);
    write_reg(REG_ROWS_A, m);
    write_reg(REG_INNER_DIM, k);
    write_reg(REG_COLS_B, n);
    write_reg(REG_UNUSED, DIM_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every C element is in, then let the sequencer finish any drop
  task automatic settle();
    in_tvalid <= 1'b0;
    while (c_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                         input logic [DATA_W-1:0] val, input logic typed,
                         input logic [DATA_W-1:0] c_value, input logic c_sat);
    dir_row_t r;
    r.op      = op;
    r.idx     = idx;
    r.val     = val;
    r.typed   = typed;
    r.c_value = c_value;
    r.c_sat   = c_sat;
    dir_rows.push_back(r);
  endtask

  // full load of the operands in force, then random beats, then one compute
  task automatic random_phase(input logic [DIM_W-1:0] m_raw, input logic [DIM_W-1:0] k_raw,
                              input logic [DIM_W-1:0] n_raw);
    int m;
    int k;
    int n;
    int pick;
    int span;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] val;
    set_dims(m_raw, k_raw, n_raw);
    steady = ($urandom_range(0, 3) == 0);
    m = dim_used(m_raw);
    k = dim_used(k_raw);
    n = dim_used(n_raw);
    // every element a compute can read gets written first
    for (int x = 0; x < m * k; x++) begin
      val = pick_value();
      send_beat(OP_WRITE_A, IDX_W'(x), val);
      mirror_beat(OP_WRITE_A, IDX_W'(x), val);
    end
    for (int x = 0; x < k * n; x++) begin
      val = pick_value();
      send_beat(OP_WRITE_B, IDX_W'(x), val);
      mirror_beat(OP_WRITE_B, IDX_W'(x), val);
    end
    for (int r = 0; r < RAND_PER_PHASE; r++) begin
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
        op   = OP_WRITE_A;
        span = m * k;
      end else if (pick < 84) begin
        op   = OP_WRITE_B;
        span = k * n;
      end else if (pick < 96) begin
        op   = OP_COMPUTE;
        span = STORE_DEPTH;
      end else begin
        op   = OP_UNUSED;
        span = STORE_DEPTH;
      end
      // now and then an index anywhere, which may fall beyond the matrix
      if ($urandom_range(0, 7) == 0) idx = IDX_W'($urandom_range(0, STORE_DEPTH - 1));
      else idx = IDX_W'($urandom_range(0, span - 1));
      val = pick_value();
      send_beat(op, idx, val);
      mirror_beat(op, idx, val);
    end
    val = $urandom;
    send_beat(OP_COMPUTE, IDX_W'($urandom), val);
    mirror_beat(OP_COMPUTE, '0, '0);
    settle();
  endtask

  // result side: random back-pressure, none in steady phases
  initial begin
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_tready <= 1'b0;
      end else begin
        stall_left = pause_len();
        out_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left = stall_left - 1;
      end
    end
  end

  // every accepted result beat against the oldest expected C element
  always @(posedge clk) begin : check_c
    c_elem_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (c_expected.size() == 0) begin
        $error("result beat with nothing expected: value %h row %0d col %0d",
               out_tdata[31:0], out_tdata[34:32], out_tdata[37:35]);
        errors++;
      end else begin
        want = c_expected.pop_front();
        if (out_tdata[31:0] !== want.value) begin
          $error("result_value: expected %h, actual %h", want.value, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[34:32] !== want.row) begin
          $error("result_row: expected %0d, actual %0d", want.row, out_tdata[34:32]);
          errors++;
        end
        if (out_tdata[37:35] !== want.col) begin
          $error("result_col: expected %0d, actual %0d", want.col, out_tdata[37:35]);
          errors++;
        end
        if (out_tdata[38] !== want.sat) begin
          $error("saturated: expected %0b, actual %0b", want.sat, out_tdata[38]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    c_elem_t typed_c;
    // directed table, run at the reset dimensions 1 x 1 x 1
    // largest positive squared: far beyond range
    add_row(OP_WRITE_A, 6'd0, SAT_POS, 1'b0, '0, 1'b0);
    add_row(OP_WRITE_B, 6'd0, SAT_POS, 1'b0, '0, 1'b0);
    add_row(OP_COMPUTE, 6'd0, '0, 1'b1, SAT_POS, 1'b1);
    // most negative squared: positive clip
    add_row(OP_WRITE_A, 6'd0, SAT_NEG, 1'b0, '0, 1'b0);
    add_row(OP_WRITE_B, 6'd0, SAT_NEG, 1'b0, '0, 1'b0);
    add_row(OP_COMPUTE, 6'd63, 32'hFFFFFFFF, 1'b1, SAT_POS, 1'b1);
    // mixed signs: negative clip
    add_row(OP_WRITE_B, 6'd0, SAT_POS, 1'b0, '0, 1'b0);
    add_row(OP_COMPUTE, 6'd0, '0, 1'b1, SAT_NEG, 1'b1);
    // 1.0 times x gives x back
    add_row(OP_WRITE_A, 6'd0, 32'h00010000, 1'b0, '0, 1'b0);
    add_row(OP_WRITE_B, 6'd0, 32'h12345678, 1'b0, '0, 1'b0);
    add_row(OP_COMPUTE, 6'd0, '0, 1'b1, 32'h12345678, 1'b0);
    // tiny negative product floors to minus one lsb
    add_row(OP_WRITE_A, 6'd0, 32'hFFFFFFFF, 1'b0, '0, 1'b0);
    add_row(OP_WRITE_B, 6'd0, 32'h00000001, 1'b0, '0, 1'b0);
    add_row(OP_COMPUTE, 6'd0, '0, 1'b1, 32'hFFFFFFFF, 1'b1 ^ 1'b1);
    // writes beyond the 1 x 1 matrices and the unused op change nothing
    add_row(OP_WRITE_A, 6'd63, 32'h0BAD0BAD, 1'b0, '0, 1'b0);
    add_row(OP_WRITE_B, 6'd1, 32'h0BAD0BAD, 1'b0, '0, 1'b0);
    add_row(OP_UNUSED, 6'd0, 32'hFFFFFFFF, 1'b0, '0, 1'b0);
    add_row(OP_COMPUTE, 6'd0, '0, 1'b1, 32'hFFFFFFFF, 1'b0);
    // ordinary fractional products, left to the shadow model
    add_row(OP_WRITE_B, 6'd0, SAT_NEG, 1'b0, '0, 1'b0);
    add_row(OP_COMPUTE, 6'd0, '0, 1'b0, '0, 1'b0);
    add_row(OP_WRITE_A, 6'd0, 32'h00018000, 1'b0, '0, 1'b0);
    add_row(OP_WRITE_B, 6'd0, 32'hFFFE0000, 1'b0, '0, 1'b0);
    add_row(OP_COMPUTE, 6'd0, '0, 1'b0, '0, 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[x]) begin
      send_beat(dir_rows[x].op, dir_rows[x].idx, dir_rows[x].val);
      if (dir_rows[x].typed) begin
        typed_c.value = dir_rows[x].c_value;
        typed_c.row   = '0;
        typed_c.col   = '0;
        typed_c.sat   = dir_rows[x].c_sat;
        typed_c.last  = 1'b1;
        c_expected.push_back(typed_c);
      end else begin
        mirror_beat(dir_rows[x].op, dir_rows[x].idx, dir_rows[x].val);
      end
    end
    settle();

    // dimension settings: small shapes, zeros, widest rows and columns,
    // over-range values, the deepest sum
    random_phase(4'd2, 4'd3, 4'd2);
    random_phase(4'd0, 4'd0, 4'd0);
    random_phase(4'd8, 4'd2, 4'd8);
    random_phase(4'd15, 4'd1, 4'd9);
    random_phase(4'd1, 4'd8, 4'd1);
    random_phase(4'd3, 4'd1, 4'd5);
    random_phase(DIM_W'($urandom_range(0, 3)), DIM_W'($urandom_range(0, 3)),
                 DIM_W'($urandom_range(0, 3)));

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
